FILE: hdl/vpsc_pkg.sv
// ----------------------------------------------------------------------------
// vpsc_pkg
// Shared types and codes for the voice playback state control block.
// ----------------------------------------------------------------------------
package vpsc_pkg;

	// command codes
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_PLAY  = 2'd1;
	localparam logic [1:0] CMD_STOP  = 2'd2;
	localparam logic [1:0] CMD_PAUSE = 2'd3;

	// play state codes
	localparam logic [2:0] ST_STOPPED  = 3'd0;
	localparam logic [2:0] ST_STARTING = 3'd1;
	localparam logic [2:0] ST_PLAYING  = 3'd2;
	localparam logic [2:0] ST_PAUSING  = 3'd3;
	localparam logic [2:0] ST_PAUSED   = 3'd4;
	localparam logic [2:0] ST_STOPPING = 3'd5;

	// configuration register indexes
	localparam logic CFG_READY = 1'b0;
	localparam logic CFG_FADE  = 1'b1;

	localparam int FADE_W    = 24;
	localparam int ELAPSED_W = 20;

	localparam logic [FADE_W-1:0] FADE_RESET = 24'd55000;

	typedef struct packed {
		logic [1:0]           command;
		logic [ELAPSED_W-1:0] elapsed;
		logic                 node_playing;
		logic                 at_end;
	} item_t;

	typedef struct packed {
		logic [2:0] play_state;
		logic       accepted;
		logic       fault;
		logic       start_source;
		logic       stop_source;
		logic       seek_to_start;
		logic       fade_out_start;
		logic       fade_in_start;
		logic       notify_complete;
		logic       finished;
		logic       is_playing;
	} result_t;

endpackage

FILE: hdl/vpsc_in_stage.sv
// ----------------------------------------------------------------------------
// vpsc_in_stage
// Input register for command words; hands one word per cycle to the control
// logic whenever the result register can take its answer.
// ----------------------------------------------------------------------------
module vpsc_in_stage
	import vpsc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cmd_valid,
	output logic  cmd_stall,
	input  item_t item,
	input  logic  res_free,
	output logic  go,
	output item_t item_s1
);

	logic vld_s1;

	assign go        = vld_s1 & res_free;
	assign cmd_stall = vld_s1 & ~res_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			vld_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (cmd_valid && !cmd_stall) begin
			item_s1 <= item;
		end
	end

endmodule

FILE: hdl/vpsc_ctrl.sv
// ----------------------------------------------------------------------------
// vpsc_ctrl
// Play state machine, finished flag, fade countdown and configuration
// registers. Computes the answer to one command word combinationally.
// ----------------------------------------------------------------------------
module vpsc_ctrl
	import vpsc_pkg::*;
#(
	parameter int TIMER_WIDTH = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_index,
	input  logic [FADE_W-1:0] cfg_data,
	input  logic              go,
	input  item_t             item_s1,
	output result_t           res
);

	localparam int EXT_W = (TIMER_WIDTH > FADE_W) ? TIMER_WIDTH : FADE_W;

	logic                   ready_q;
	logic [FADE_W-1:0]      fade_q;
	logic [2:0]             st_q;
	logic                   fin_q;
	logic [TIMER_WIDTH-1:0] cd_q;

	logic [2:0]             st_n;
	logic                   fin_n;
	logic [TIMER_WIDTH-1:0] cd_n;
	logic [TIMER_WIDTH-1:0] cd_tick;
	logic [TIMER_WIDTH-1:0] fade_trunc;
	logic [EXT_W-1:0]       cd_ext;
	logic [EXT_W-1:0]       el_ext;
	logic [EXT_W-1:0]       fade_ext;
	logic [EXT_W-1:0]       diff;
	logic                   restart;

	assign cd_ext     = EXT_W'(cd_q);
	assign el_ext     = EXT_W'(item_s1.elapsed);
	assign fade_ext   = EXT_W'(fade_q);
	assign diff       = cd_ext - el_ext;
	assign cd_tick    = (cd_ext > el_ext) ? diff[TIMER_WIDTH-1:0] : '0;
	assign fade_trunc = fade_ext[TIMER_WIDTH-1:0];

	always_comb begin
		st_n    = st_q;
		fin_n   = fin_q;
		cd_n    = cd_q;
		res     = '0;
		restart = 1'b0;
		unique case (item_s1.command)
			CMD_TICK: begin
				cd_n = cd_tick;
				unique case (st_q)
					ST_STARTING: begin
						if (item_s1.node_playing) st_n = ST_PLAYING;
					end
					ST_PLAYING: begin
						// source went quiet: done, notify only at end of data
						if (!item_s1.node_playing) begin
							st_n                = ST_STOPPED;
							fin_n               = 1'b1;
							res.notify_complete = item_s1.at_end;
						end
					end
					ST_PAUSING: begin
						if (cd_tick == '0) begin
							res.stop_source = 1'b1;
							st_n            = ST_PAUSED;
						end
					end
					ST_STOPPING: begin
						if (cd_tick == '0) begin
							res.stop_source     = 1'b1;
							res.seek_to_start   = 1'b1;
							res.notify_complete = 1'b1;
							fin_n               = 1'b1;
							st_n                = ST_STOPPED;
						end
					end
					default: ;
				endcase
			end
			CMD_PLAY: begin
				if (ready_q) begin
					unique case (st_q)
						ST_STOPPED: begin
							fin_n   = 1'b0;
							restart = 1'b1;
						end
						ST_STARTING: begin
							res.fault = 1'b1;
						end
						ST_PLAYING: begin
							res.stop_source   = 1'b1;
							res.seek_to_start = 1'b1;
							fin_n             = 1'b0;
							restart           = 1'b1;
						end
						ST_PAUSING: begin
							res.stop_source = 1'b1;
							restart         = 1'b1;
						end
						ST_PAUSED: begin
							res.fade_in_start = 1'b1;
							restart           = 1'b1;
						end
						ST_STOPPING: begin
							res.stop_source     = 1'b1;
							res.seek_to_start   = 1'b1;
							res.notify_complete = 1'b1;
							fin_n               = 1'b1;
							restart             = 1'b1;
						end
						default: ;
					endcase
				end
				if (restart) begin
					res.start_source = 1'b1;
					res.accepted     = 1'b1;
					st_n             = ST_STARTING;
				end
			end
			CMD_STOP: begin
				res.accepted = 1'b1;
				unique case (st_q)
					ST_STOPPED: begin
						fin_n        = 1'b1;
						res.accepted = 1'b0;
					end
					ST_STARTING: begin
						res.stop_source   = 1'b1;
						res.seek_to_start = 1'b1;
						fin_n             = 1'b1;
						st_n              = ST_STOPPING;
					end
					ST_PLAYING: begin
						cd_n               = fade_trunc;
						res.fade_out_start = 1'b1;
						st_n               = ST_STOPPING;
					end
					ST_PAUSING, ST_PAUSED: begin
						res.stop_source     = 1'b1;
						res.seek_to_start   = 1'b1;
						res.notify_complete = 1'b1;
						fin_n               = 1'b1;
						st_n                = ST_STOPPING;
					end
					ST_STOPPING: begin
						res.stop_source     = 1'b1;
						res.seek_to_start   = 1'b1;
						res.notify_complete = 1'b1;
						fin_n               = 1'b1;
						st_n                = ST_STOPPED;
					end
					default: ;
				endcase
			end
			CMD_PAUSE: begin
				res.accepted = 1'b1;
				if (st_q == ST_PLAYING) begin
					cd_n               = fade_trunc;
					res.fade_out_start = 1'b1;
					st_n               = ST_PAUSING;
				end else if (st_q <= ST_STOPPING) begin
					st_n = ST_PAUSED;
				end
			end
		endcase
		res.play_state = st_n;
		res.finished   = fin_n;
		res.is_playing = (st_n != ST_STOPPED) && (st_n != ST_PAUSED);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_STOPPED;
			fin_q <= 1'b0;
			cd_q  <= '0;
		end else if (go) begin
			st_q  <= st_n;
			fin_q <= fin_n;
			cd_q  <= cd_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
			fade_q  <= FADE_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_READY) begin
				ready_q <= cfg_data[0];
			end else begin
				fade_q <= cfg_data;
			end
		end
	end

`ifndef SYNTHESIS
	a_play_fault_holds: assert property (@(posedge clk) disable iff (!arst_n)
		go && item_s1.command == CMD_PLAY && ready_q && st_q == ST_STARTING
		|=> st_q == ST_STARTING)
		else $error("play while starting changed the state");

	a_stop_done: assert property (@(posedge clk) disable iff (!arst_n)
		go && item_s1.command == CMD_TICK && st_q == ST_STOPPING && cd_tick == '0
		|=> st_q == ST_STOPPED && fin_q)
		else $error("stopping did not finish when the fade wait ran out");

	a_fade_load: assert property (@(posedge clk) disable iff (!arst_n)
		go && res.fade_out_start |=> cd_q == $past(fade_trunc))
		else $error("fade countdown not loaded on fade out");

	a_state_legal: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> st_q <= ST_STOPPING)
		else $error("play state left the legal range");
`endif

endmodule

FILE: hdl/vpsc_out_stage.sv
// ----------------------------------------------------------------------------
// vpsc_out_stage
// Result register; holds a finished answer until the receiver takes it.
// ----------------------------------------------------------------------------
module vpsc_out_stage
	import vpsc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    go,
	input  result_t res,
	input  logic    res_stall,
	output logic    res_free,
	output logic    vld_s2,
	output result_t res_s2
);

	assign res_free = ~vld_s2 | ~res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (go) begin
			vld_s2 <= 1'b1;
		end else if (!res_stall) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_s2 <= res;
		end
	end

endmodule

FILE: hdl/voice_playback_state_control_core.sv
// ----------------------------------------------------------------------------
// voice_playback_state_control_core
// Lifecycle control of one audio voice: play state, finished flag and fade
// countdown, with source and fader pulses answered per command word.
//
//   channel   | handshake              | word
//   ----------+------------------------+----------------------------------
//   command   | cmd_valid / cmd_stall  | command, elapsed, node_playing,
//             |                        | at_end
//   result    | res_valid / res_stall  | play_state .. is_playing
//   config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One command word per cycle while no stall holds the flow; a taken word is
// held in the input register while the state update computes its answer,
// and that answer is then registered in the result register.
// Reset clears the state to stopped, finished to 0, countdown to 0,
// ready_cfg to 0 and fade_ticks to 55000. No clearing pass.
// A stalled result holds; the input register keeps taking words until it
// holds one that cannot move on, then cmd_stall rises.
// ----------------------------------------------------------------------------
module voice_playback_state_control_core
	import vpsc_pkg::*;
#(
	parameter int TIMER_WIDTH = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  logic [1:0]           command,
	input  logic [ELAPSED_W-1:0] elapsed,
	input  logic                 node_playing,
	input  logic                 at_end,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [2:0]           play_state,
	output logic                 accepted,
	output logic                 fault,
	output logic                 start_source,
	output logic                 stop_source,
	output logic                 seek_to_start,
	output logic                 fade_out_start,
	output logic                 fade_in_start,
	output logic                 notify_complete,
	output logic                 finished,
	output logic                 is_playing,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_index,
	input  logic [FADE_W-1:0]    cfg_data
);

	item_t   item;
	item_t   item_s1;
	result_t res;
	result_t res_s2;
	logic    go;
	logic    res_free;

	assign cfg_ready = 1'b1;

	assign item.command      = command;
	assign item.elapsed      = elapsed;
	assign item.node_playing = node_playing;
	assign item.at_end       = at_end;

	vpsc_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.item      (item),
		.res_free  (res_free),
		.go        (go),
		.item_s1   (item_s1)
	);

	vpsc_ctrl #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.go        (go),
		.item_s1   (item_s1),
		.res       (res)
	);

	vpsc_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.res       (res),
		.res_stall (res_stall),
		.res_free  (res_free),
		.vld_s2    (res_valid),
		.res_s2    (res_s2)
	);

	assign play_state      = res_s2.play_state;
	assign accepted        = res_s2.accepted;
	assign fault           = res_s2.fault;
	assign start_source    = res_s2.start_source;
	assign stop_source     = res_s2.stop_source;
	assign seek_to_start   = res_s2.seek_to_start;
	assign fade_out_start  = res_s2.fade_out_start;
	assign fade_in_start   = res_s2.fade_in_start;
	assign notify_complete = res_s2.notify_complete;
	assign finished        = res_s2.finished;
	assign is_playing      = res_s2.is_playing;

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for voice_playback_state_control_core. A driver and a
// monitor, each a clocked block with random gaps and stalls, feed command
// words and take result words. A local model of the voice state machine
// predicts every result when its command word is taken, and the monitor
// checks each result field by field. Configuration is rewritten between
// phases while the block is idle: not ready, short fades, zero and maximum
// fade length, and random lengths.
// ----------------------------------------------------------------------------
module tb
	import vpsc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// no handshake for this many cycles ends the run
	localparam int unsigned HANG_LIMIT = 1000;
	localparam int unsigned SETTLE_CYCLES = 4;

	typedef struct {
		item_t word;
		bit    drain;
	} pending_word_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cmd_valid = 1'b0;
	logic                 cmd_stall;
	logic [1:0]           command = CMD_TICK;
	logic [ELAPSED_W-1:0] elapsed = '0;
	logic                 node_playing = 1'b0;
	logic                 at_end = 1'b0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	logic [2:0]           play_state;
	logic                 accepted;
	logic                 fault;
	logic                 start_source;
	logic                 stop_source;
	logic                 seek_to_start;
	logic                 fade_out_start;
	logic                 fade_in_start;
	logic                 notify_complete;
	logic                 finished;
	logic                 is_playing;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic                 cfg_index = CFG_READY;
	logic [FADE_W-1:0]    cfg_data = '0;

	// model of the voice
	logic [2:0]        voice_state = ST_STOPPED;
	logic              voice_done = 1'b0;
	logic [FADE_W-1:0] fade_left = '0;
	logic              src_ready = 1'b0;
	logic [FADE_W-1:0] fade_len = FADE_RESET;

	pending_word_t commands_pending[$];
	result_t       answers_due[$];
	pending_word_t cur_word;
	result_t       want;
	bit            word_busy = 1'b0;
	bit            tx_quiet = 1'b0;
	bit            rx_quiet = 1'b0;
	int unsigned   tx_gap = 0;
	int unsigned   rx_wait = 0;
	int unsigned   results_seen = 0;
	int unsigned   mismatches = 0;
	int unsigned   idle_cycles = 0;

	voice_playback_state_control_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_stall      (cmd_stall),
		.command        (command),
		.elapsed        (elapsed),
		.node_playing   (node_playing),
		.at_end         (at_end),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.play_state     (play_state),
		.accepted       (accepted),
		.fault          (fault),
		.start_source   (start_source),
		.stop_source    (stop_source),
		.seek_to_start  (seek_to_start),
		.fade_out_start (fade_out_start),
		.fade_in_start  (fade_in_start),
		.notify_complete(notify_complete),
		.finished       (finished),
		.is_playing     (is_playing),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Advance the voice by one command word and return the answer it gives.
	function automatic result_t advance_voice(input item_t w);
		result_t    r;
		logic [2:0] s;
		bit         go;
		r = '0;
		s = voice_state;
		case (w.command)
			CMD_TICK: begin
				fade_left = (fade_left > w.elapsed) ? fade_left - w.elapsed : '0;
				case (s)
					ST_STARTING: begin
						if (w.node_playing)
							voice_state = ST_PLAYING;
					end
					ST_PLAYING: begin
						if (!w.node_playing) begin
							voice_state = ST_STOPPED;
							voice_done = 1'b1;
							r.notify_complete = w.at_end;
						end
					end
					ST_PAUSING: begin
						if (fade_left == '0) begin
							r.stop_source = 1'b1;
							voice_state = ST_PAUSED;
						end
					end
					ST_STOPPING: begin
						if (fade_left == '0) begin
							r.stop_source = 1'b1;
							r.seek_to_start = 1'b1;
							r.notify_complete = 1'b1;
							voice_done = 1'b1;
							voice_state = ST_STOPPED;
						end
					end
					default: ;
				endcase
			end
			CMD_PLAY: begin
				if (src_ready) begin
					go = 1'b1;
					case (s)
						ST_STOPPED: voice_done = 1'b0;
						ST_STARTING: begin
							r.fault = 1'b1;
							go = 1'b0;
						end
						ST_PLAYING: begin
							r.stop_source = 1'b1;
							r.seek_to_start = 1'b1;
							voice_done = 1'b0;
						end
						ST_PAUSING: r.stop_source = 1'b1;
						ST_PAUSED: r.fade_in_start = 1'b1;
						ST_STOPPING: begin
							r.stop_source = 1'b1;
							r.seek_to_start = 1'b1;
							r.notify_complete = 1'b1;
							voice_done = 1'b1;
						end
						default: go = 1'b0;
					endcase
					if (go) begin
						r.start_source = 1'b1;
						r.accepted = 1'b1;
						voice_state = ST_STARTING;
					end
				end
			end
			CMD_STOP: begin
				r.accepted = 1'b1;
				case (s)
					ST_STOPPED: begin
						voice_done = 1'b1;
						r.accepted = 1'b0;
					end
					ST_STARTING: begin
						// countdown keeps its old value here
						r.stop_source = 1'b1;
						r.seek_to_start = 1'b1;
						voice_done = 1'b1;
						voice_state = ST_STOPPING;
					end
					ST_PLAYING: begin
						fade_left = fade_len;
						r.fade_out_start = 1'b1;
						voice_state = ST_STOPPING;
					end
					ST_PAUSING, ST_PAUSED, ST_STOPPING: begin
						r.stop_source = 1'b1;
						r.seek_to_start = 1'b1;
						r.notify_complete = 1'b1;
						voice_done = 1'b1;
						voice_state = (s == ST_STOPPING) ? ST_STOPPED : ST_STOPPING;
					end
					default: ;
				endcase
			end
			default: begin
				r.accepted = 1'b1;
				if (s == ST_PLAYING) begin
					fade_left = fade_len;
					r.fade_out_start = 1'b1;
					voice_state = ST_PAUSING;
				end else if (s <= ST_STOPPING) begin
					voice_state = ST_PAUSED;
				end
			end
		endcase
		r.play_state = voice_state;
		r.finished = voice_done;
		r.is_playing = (voice_state != ST_STOPPED) && (voice_state != ST_PAUSED);
		return r;
	endfunction

	function automatic int unsigned draw_wait(input bit quiet);
		return quiet ? 0 : $urandom_range(0, 18);
	endfunction

	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [2:0] got,
			input logic [2:0] exp_val);
		if (got !== exp_val)
			report_error($sformatf("result %0d: %s is %0d, expected %0d",
				results_seen, name, got, exp_val));
	endtask

	// driver: hold a stalled word, otherwise wait out the gap and send the next
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall) begin
				answers_due.push_back(advance_voice(cur_word.word));
				word_busy = 1'b0;
				if ($urandom_range(0, 39) == 0)
					tx_quiet = !tx_quiet;
				tx_gap = draw_wait(tx_quiet);
			end
			if (!(cmd_valid && cmd_stall)) begin
				if (tx_gap != 0) begin
					tx_gap--;
					cmd_valid <= 1'b0;
				end else if (commands_pending.size() != 0 &&
						!(commands_pending[0].drain && answers_due.size() != 0)) begin
					cur_word = commands_pending.pop_front();
					word_busy = 1'b1;
					cmd_valid <= 1'b1;
					command <= cur_word.word.command;
					elapsed <= cur_word.word.elapsed;
					node_playing <= cur_word.word.node_playing;
					at_end <= cur_word.word.at_end;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: take a result word, check it, draw the next stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				results_seen++;
				if (answers_due.size() == 0) begin
					report_error($sformatf("result %0d arrived with nothing pending",
						results_seen));
				end else begin
					want = answers_due.pop_front();
					check_field("play_state", play_state, want.play_state);
					check_field("accepted", 3'(accepted), 3'(want.accepted));
					check_field("fault", 3'(fault), 3'(want.fault));
					check_field("start_source", 3'(start_source),
						3'(want.start_source));
					check_field("stop_source", 3'(stop_source), 3'(want.stop_source));
					check_field("seek_to_start", 3'(seek_to_start),
						3'(want.seek_to_start));
					check_field("fade_out_start", 3'(fade_out_start),
						3'(want.fade_out_start));
					check_field("fade_in_start", 3'(fade_in_start),
						3'(want.fade_in_start));
					check_field("notify_complete", 3'(notify_complete),
						3'(want.notify_complete));
					check_field("finished", 3'(finished), 3'(want.finished));
					check_field("is_playing", 3'(is_playing), 3'(want.is_playing));
				end
				if ($urandom_range(0, 39) == 0)
					rx_quiet = !rx_quiet;
				rx_wait = draw_wait(rx_quiet);
			end
			if (rx_wait != 0) begin
				rx_wait--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) ||
				(cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= HANG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic write_reg(input logic idx, input logic [FADE_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_READY)
			src_ready = val[0];
		else
			fade_len = val;
	endtask

	task automatic queue_word(input logic [1:0] cmd, input logic [ELAPSED_W-1:0] el,
			input bit np, input bit ae, input bit drain);
		pending_word_t p;
		p.word.command = cmd;
		p.word.elapsed = el;
		p.word.node_playing = np;
		p.word.at_end = ae;
		p.drain = drain;
		commands_pending.push_back(p);
	endtask

	task automatic queue_random_word();
		logic [1:0]           cmd;
		logic [ELAPSED_W-1:0] el;
		int unsigned          span;
		int unsigned          pick;
		pick = $urandom_range(0, 19);
		if (pick < 10)
			cmd = CMD_TICK;
		else if (pick < 14)
			cmd = CMD_PLAY;
		else if (pick < 17)
			cmd = CMD_STOP;
		else
			cmd = CMD_PAUSE;
		// mostly steps that are small against the fade, so waits run down in a few ticks
		span = (fade_len > 24'hFFFFF) ? 32'hFFFFF : fade_len;
		case ($urandom_range(0, 9))
			0, 1: el = '0;
			2: el = '1;
			3, 4, 5: el = ELAPSED_W'($urandom_range(0, 32'hFFFFF));
			default: el = ELAPSED_W'($urandom_range(0, span / 3 + 1));
		endcase
		queue_word(cmd, el, $urandom_range(0, 3) != 0, $urandom_range(0, 1) != 0,
			$urandom_range(0, 59) == 0);
	endtask

	// wait until every word is taken and answered, then let the pipeline settle
	task automatic wait_idle();
		while (commands_pending.size() != 0 || word_busy || answers_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int unsigned       n_words;
		logic              rdy;
		logic [FADE_W-1:0] fade;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: source not ready, default fade
		queue_word(CMD_PLAY, '0, 1'b1, 1'b1, 1'b0);
		queue_word(CMD_STOP, '0, 1'b0, 1'b0, 1'b0);
		queue_word(CMD_PAUSE, '0, 1'b0, 1'b0, 1'b0);
		queue_word(CMD_STOP, '0, 1'b0, 1'b0, 1'b0);
		queue_word(CMD_TICK, '0, 1'b0, 1'b0, 1'b0);
		wait_idle();

		write_reg(CFG_FADE, 24'd3);
		write_reg(CFG_READY, 24'd1);
		queue_word(CMD_PLAY, '0, 1'b0, 1'b0, 1'b0);
		queue_word(CMD_PLAY, '0, 1'b0, 1'b0, 1'b0);
		queue_word(CMD_TICK, '0, 1'b0, 1'b1, 1'b0);
		queue_word(CMD_TICK, 20'd1, 1'b1, 1'b0, 1'b0);
		queue_word(CMD_PLAY, '0, 1'b0, 1'b0, 1'b0);
		queue_word(CMD_TICK, '0, 1'b1, 1'b0, 1'b0);
		queue_word(CMD_PAUSE, '0, 1'b0, 1'b0, 1'b1);
		queue_word(CMD_TICK, 20'd1, 1'b1, 1'b1, 1'b0);
		queue_word(CMD_PLAY, '0, 1'b0, 1'b0, 1'b0);
		queue_word(CMD_TICK, '0, 1'b1, 1'b0, 1'b0);
		queue_word(CMD_PAUSE, '0, 1'b0, 1'b0, 1'b0);
		queue_word(CMD_TICK, 20'hFFFFF, 1'b0, 1'b0, 1'b0);
		queue_word(CMD_PLAY, '0, 1'b0, 1'b0, 1'b0);
		queue_word(CMD_STOP, '0, 1'b0, 1'b0, 1'b0);
		queue_word(CMD_STOP, '0, 1'b0, 1'b0, 1'b0);
		queue_word(CMD_PLAY, '0, 1'b0, 1'b0, 1'b0);
		queue_word(CMD_TICK, 20'hAAAAA, 1'b1, 1'b0, 1'b0);
		queue_word(CMD_TICK, 20'h55555, 1'b0, 1'b1, 1'b0);
		queue_word(CMD_PLAY, '0, 1'b0, 1'b0, 1'b0);
		queue_word(CMD_TICK, '0, 1'b1, 1'b0, 1'b0);
		queue_word(CMD_STOP, '0, 1'b0, 1'b0, 1'b0);
		queue_word(CMD_PLAY, '0, 1'b0, 1'b0, 1'b0);
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			rdy = 1'b1;
			n_words = 340;
			case (p)
				0: fade = FADE_W'($urandom_range(0, 40));
				1: fade = '0;
				2: fade = '1;
				3: begin
					rdy = 1'b0;
					fade = FADE_W'($urandom_range(0, 40));
					n_words = 150;
				end
				4: fade = FADE_W'($urandom);
				default: fade = FADE_W'($urandom_range(1, 200));
			endcase
			write_reg(CFG_READY, FADE_W'(rdy));
			write_reg(CFG_FADE, fade);
			repeat (n_words) queue_random_word();
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (answers_due.size() != 0)
			report_error($sformatf("%0d results never arrived", answers_due.size()));
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
